// ===== hw/rtl/fcgc_pkg.sv =====
// ----------------------------------------------------------------------------
// fcgc_pkg
// Shared types and codes for the frame counter gap classifier.
// ----------------------------------------------------------------------------
package fcgc_pkg;

  // Width of the request data word and of the missing-frame count
  localparam int unsigned DataWidth = 64;
  localparam int unsigned KindWidth = 3;

  // Command carried in tuser of a request
  localparam logic CmdClassify = 1'b0;
  localparam logic CmdClear    = 1'b1;

  typedef enum logic [KindWidth-1:0] {
    KIND_FIRST     = 3'd0,
    KIND_DUPLICATE = 3'd1,
    KIND_BACKWARD  = 3'd2,
    KIND_NORMAL    = 3'd3,
    KIND_GAP       = 3'd4
  } frame_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUB  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

endpackage

// ===== hw/rtl/frame_counter_gap_classifier.sv =====
// ----------------------------------------------------------------------------
// frame_counter_gap_classifier
// Classifies frame counters as first, duplicate, backward, normal or gap, and
// estimates missing frames for a gap. Bit-serial compare/subtract, then a
// restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
// Sequence: a clear is taken in ST_IDLE and gives no result; a first counter goes
//   straight to ST_FIN, a duplicate, backward or normal one first passes the
//   bit-serial subtract in ST_SUB, and a gap then runs the divider in ST_DIV.
// Requests: one at a time; a new request is taken only once the result of the
//   last one has been registered in ST_FIN.
// Reset: asynchronous, active low; clears the tracker and any pending result.
module frame_counter_gap_classifier #(
  parameter int unsigned COUNTER_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // [63:0] counter_value
  input  logic        s_axis_tuser_i,  // [0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // [63:0] missing_frames
  output logic [2:0]  m_axis_tuser_o   // [2:0] frame_kind
);

  localparam int unsigned W  = COUNTER_WIDTH;
  localparam int unsigned BW = $clog2(COUNTER_WIDTH);

  fcgc_pkg::state_e      state_q;
  fcgc_pkg::frame_kind_e kind_q;
  logic [W-1:0]  cnt_q, last_q, step_q, delta_q, rem_q;
  logic          seen_q;
  logic [BW-1:0] bit_q;
  logic          bor1_q, bor2_q, dnz_q, enz_q, snz_q;
  logic          out_valid_q, out_valid_d;
  logic [fcgc_pkg::KindWidth-1:0] out_kind_q;
  logic [fcgc_pkg::DataWidth-1:0] out_miss_q;

  logic          in_acc, out_free;
  logic          a_bit, b_bit, s_bit, d_bit, e_bit, bor1_d, bor2_d;
  logic          step_take;
  logic [W-1:0]  delta_d;
  logic [W:0]    div_tmp, div_diff;
  logic          div_ge;
  logic [W-1:0]  q_dec;

  assign s_axis_tready_o = (state_q == fcgc_pkg::ST_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~out_valid_q | m_axis_tready_i;
  assign out_valid_d     = ((state_q == fcgc_pkg::ST_FIN) & out_free) |
                           (out_valid_q & ~m_axis_tready_i);

  // Serial subtract: delta = cnt - last, and delta - step alongside
  assign a_bit   = cnt_q[0];
  assign b_bit   = last_q[0];
  assign s_bit   = step_q[0];
  assign d_bit   = a_bit ^ b_bit ^ bor1_q;
  assign bor1_d  = (~a_bit & b_bit) | (~(a_bit ^ b_bit) & bor1_q);
  assign e_bit   = d_bit ^ s_bit ^ bor2_q;
  assign bor2_d  = (~d_bit & s_bit) | (~(d_bit ^ s_bit) & bor2_q);
  assign delta_d = {d_bit, delta_q[W-1:1]};

  // Take delta as the new step when no step is learned yet or delta is smaller
  assign step_take = ~(snz_q | s_bit) | bor2_d;

  // Restoring divide step
  assign div_tmp  = {rem_q, delta_q[W-1]};
  assign div_diff = div_tmp - {1'b0, step_q};
  assign div_ge   = ~div_diff[W];
  assign q_dec    = delta_q - W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fcgc_pkg::ST_IDLE;
      kind_q      <= fcgc_pkg::KIND_FIRST;
      seen_q      <= 1'b0;
      last_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        fcgc_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser_i == fcgc_pkg::CmdClear) begin
              seen_q <= 1'b0;
              last_q <= '0;
              step_q <= '0;
            end else if (!seen_q) begin
              seen_q  <= 1'b1;
              last_q  <= s_axis_tdata_i[W-1:0];
              kind_q  <= fcgc_pkg::KIND_FIRST;
              state_q <= fcgc_pkg::ST_FIN;
            end else begin
              state_q <= fcgc_pkg::ST_SUB;
            end
          end
        end
        fcgc_pkg::ST_SUB: begin
          if (bit_q != '0) begin
            // rotate so the stored words return intact after a full pass
            last_q <= {b_bit, last_q[W-1:1]};
            step_q <= {s_bit, step_q[W-1:1]};
          end else if (!(dnz_q | d_bit)) begin
            last_q  <= {b_bit, last_q[W-1:1]};
            step_q  <= {s_bit, step_q[W-1:1]};
            kind_q  <= fcgc_pkg::KIND_DUPLICATE;
            state_q <= fcgc_pkg::ST_FIN;
          end else if (bor1_d) begin
            last_q  <= {b_bit, last_q[W-1:1]};
            step_q  <= {s_bit, step_q[W-1:1]};
            kind_q  <= fcgc_pkg::KIND_BACKWARD;
            state_q <= fcgc_pkg::ST_FIN;
          end else begin
            last_q <= {a_bit, cnt_q[W-1:1]};
            step_q <= step_take ? delta_d : {s_bit, step_q[W-1:1]};
            if (step_take || !(enz_q | e_bit)) begin
              kind_q  <= fcgc_pkg::KIND_NORMAL;
              state_q <= fcgc_pkg::ST_FIN;
            end else begin
              kind_q  <= fcgc_pkg::KIND_GAP;
              state_q <= fcgc_pkg::ST_DIV;
            end
          end
        end
        fcgc_pkg::ST_DIV: begin
          if (bit_q == '0) begin
            state_q <= fcgc_pkg::ST_FIN;
          end
        end
        fcgc_pkg::ST_FIN: begin
          if (out_free) begin
            state_q <= fcgc_pkg::ST_IDLE;
          end
        end
        default: state_q <= fcgc_pkg::ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      fcgc_pkg::ST_IDLE: begin
        cnt_q  <= s_axis_tdata_i[W-1:0];
        bit_q  <= BW'(W - 1);
        bor1_q <= 1'b0;
        bor2_q <= 1'b0;
        dnz_q  <= 1'b0;
        enz_q  <= 1'b0;
        snz_q  <= 1'b0;
      end
      fcgc_pkg::ST_SUB: begin
        cnt_q   <= {a_bit, cnt_q[W-1:1]};
        delta_q <= delta_d;
        bor1_q  <= bor1_d;
        bor2_q  <= bor2_d;
        dnz_q   <= dnz_q | d_bit;
        enz_q   <= enz_q | e_bit;
        snz_q   <= snz_q | s_bit;
        rem_q   <= '0;
        bit_q   <= (bit_q == '0) ? BW'(W - 1) : bit_q - BW'(1);
      end
      fcgc_pkg::ST_DIV: begin
        rem_q   <= div_ge ? div_diff[W-1:0] : div_tmp[W-1:0];
        delta_q <= {delta_q[W-2:0], div_ge};
        bit_q   <= bit_q - BW'(1);
      end
      fcgc_pkg::ST_FIN: begin
        if (out_free) begin
          out_kind_q <= kind_q;
          if (kind_q != fcgc_pkg::KIND_GAP) begin
            out_miss_q <= '0;
          end else if (delta_q > W'(2)) begin
            out_miss_q <= fcgc_pkg::DataWidth'(q_dec);
          end else begin
            out_miss_q <= fcgc_pkg::DataWidth'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_miss_q;
  assign m_axis_tuser_o  = out_kind_q;

endmodule

// ===== hw/rtl/fcgc_checker.sv =====
// ----------------------------------------------------------------------------
// fcgc_port_checker
// Port-level checks for the frame counter gap classifier.
// ----------------------------------------------------------------------------
module fcgc_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [63:0] s_axis_tdata_i,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i & s_axis_tready_o;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // Non-gap results carry a zero count
  a_zero_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != fcgc_pkg::KIND_GAP |-> m_axis_tdata_o == '0)
    else $error("missing count on non-gap result");

  // Gap results count at least one missing frame
  a_gap_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == fcgc_pkg::KIND_GAP |-> m_axis_tdata_o != '0)
    else $error("gap without missing frames");

  // A classify request keeps the block busy; a clear produces no result
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser_i == fcgc_pkg::CmdClassify |=> !s_axis_tready_o)
    else $error("request taken while busy");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser_i == fcgc_pkg::CmdClear |=> !$rose(m_axis_tvalid_o))
    else $error("clear produced a result");

endmodule

bind frame_counter_gap_classifier fcgc_port_checker u_fcgc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== bench/fcgc_checker.sv =====
// ----------------------------------------------------------------------------
// fcgc_checker
// Watches the request and result streams of the frame counter gap classifier,
// keeps its own copy of the tracker, predicts the verdict for each accepted
// counter and compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module fcgc_checker #(
  parameter int unsigned CounterWidth = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [63:0] req_counter_i,
  input  logic        req_cmd_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [63:0] rsp_missing_i,
  input  logic [2:0]  rsp_kind_i,
  output int          fail_count_o,
  output int          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] CounterMask = {64{1'b1}} >> (64 - CounterWidth);

  typedef struct packed {
    fcgc_pkg::frame_kind_e kind;
    logic [63:0]           missing;
  } frame_verdict_t;

  frame_verdict_t verdict_q[$];

  logic        tracking_q;
  logic [63:0] last_good_q;
  logic [63:0] step_q;

  // Classify one counter and advance the tracker copy
  function automatic frame_verdict_t classify_counter(input logic [63:0] raw);
    frame_verdict_t v;
    logic [63:0]    cnt;
    logic [63:0]    delta;
    logic [63:0]    quot;
    cnt       = raw & CounterMask;
    v.missing = '0;
    if (!tracking_q) begin
      tracking_q  = 1'b1;
      last_good_q = cnt;
      v.kind      = fcgc_pkg::KIND_FIRST;
    end else if (cnt == last_good_q) begin
      v.kind = fcgc_pkg::KIND_DUPLICATE;
    end else if (cnt < last_good_q) begin
      v.kind = fcgc_pkg::KIND_BACKWARD;
    end else begin
      delta = cnt - last_good_q;
      if (step_q == '0 || delta < step_q) step_q = delta;
      if (delta == step_q) begin
        v.kind = fcgc_pkg::KIND_NORMAL;
      end else begin
        quot      = delta / step_q;
        v.kind    = fcgc_pkg::KIND_GAP;
        // an uneven gap still loses at least one frame
        v.missing = (quot > 64'd2) ? quot - 64'd1 : 64'd1;
      end
      last_good_q = cnt;
    end
    return v;
  endfunction

  task automatic log_mismatch(input string what);
    if (fail_count_o < 10) $display("[%0t] MISMATCH %s", $realtime, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    frame_verdict_t want;
    if (!rst_ni) begin
      tracking_q    = 1'b0;
      last_good_q   = '0;
      step_q        = '0;
      verdict_q.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
    end else begin
      // results first: a request accepted at this edge cannot answer yet
      if (rsp_valid_i && rsp_ready_i) begin
        if (verdict_q.size() == 0) begin
          log_mismatch($sformatf("unexpected result kind=%0d missing=%0d",
                                 rsp_kind_i, rsp_missing_i));
        end else begin
          want = verdict_q.pop_front();
          if (rsp_kind_i !== want.kind || rsp_missing_i !== want.missing) begin
            log_mismatch($sformatf("kind exp=%0d got=%0d, missing exp=%0d got=%0d",
                                   want.kind, rsp_kind_i, want.missing,
                                   rsp_missing_i));
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        if (req_cmd_i == fcgc_pkg::CmdClear) begin
          tracking_q  = 1'b0;
          last_good_q = '0;
          step_q      = '0;
        end else begin
          verdict_q.push_back(classify_counter(req_counter_i));
        end
      end
      outstanding_o = verdict_q.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the frame counter gap classifier with directed corner counters and
// then with random frame streams (steady steps, gaps, duplicates, backward
// jumps, step changes and noise), with random idling on both streams. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CounterWidth = 64;
  localparam int unsigned RandomItems  = 1400;
  localparam int unsigned QuietTail    = 200;

  logic        clk;
  logic        rst_n;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  int          check_failures;
  int          check_pending;
  bit          tx_idle_en;
  bit          rx_stall_en;
  int unsigned rx_stall_left;
  int unsigned sent_count;

  frame_counter_gap_classifier #(
    .COUNTER_WIDTH (CounterWidth)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  fcgc_checker #(
    .CounterWidth (CounterWidth)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_i   (s_axis_tready),
    .req_counter_i (s_axis_tdata),
    .req_cmd_i     (s_axis_tuser),
    .rsp_valid_i   (m_axis_tvalid),
    .rsp_ready_i   (m_axis_tready),
    .rsp_missing_i (m_axis_tdata),
    .rsp_kind_i    (m_axis_tuser),
    .fail_count_o  (check_failures),
    .outstanding_o (check_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side back-pressure in random bursts
  always @(negedge clk) begin
    if (!rst_n || !rx_stall_en) begin
      m_axis_tready <= 1'b1;
      rx_stall_left <= 0;
    end else if (rx_stall_left != 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left <= $urandom_range(1, 18) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Present one request and hold it until accepted, then maybe idle
  task automatic send_request(input logic cmd, input logic [63:0] counter);
    int unsigned gap;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= counter;
    do @(posedge clk); while (!s_axis_tready);
    sent_count++;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= rand_word();
      s_axis_tuser  <= 1'($urandom_range(0, 1));
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // One stream of frame counters around a chosen step, with faults mixed in
  task automatic run_frame_stream(input int unsigned n_items);
    logic [63:0] step;
    logic [63:0] base;
    logic [63:0] next;
    int unsigned pick;
    if ($urandom_range(0, 3) != 0) send_request(fcgc_pkg::CmdClear, rand_word());
    case ($urandom_range(0, 3))
      0:       step = 64'($urandom_range(1, 8));
      1:       step = 64'($urandom_range(1, 5000));
      2:       step = {32'h0, $urandom};
      default: step = rand_word() >> $urandom_range(1, 40);
    endcase
    if (step == '0) step = 64'd1;
    case ($urandom_range(0, 2))
      0:       base = 64'($urandom_range(0, 1000));
      1:       base = 64'hFFFF_FFFF_FFFF_FFFF - step * 64'($urandom_range(0, 20));
      default: base = rand_word();
    endcase
    send_request(fcgc_pkg::CmdClassify, base);
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        next = base + step;
      end else if (pick < 72) begin
        next = base + step * 64'($urandom_range(2, 6));
      end else if (pick < 80) begin
        next = base + step * 64'($urandom_range(1, 4)) + rand_word() % step;
      end else if (pick < 86) begin
        next = base;
      end else if (pick < 91) begin
        next = (base == '0) ? base : base - 64'd1 - rand_word() % base;
      end else if (pick < 95) begin
        // tighten the frame rate
        if (step > 64'd1) step = step >> 1;
        next = base + step;
      end else begin
        next = rand_word();
      end
      send_request(fcgc_pkg::CmdClassify, next);
      if (next > base) base = next;
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = fcgc_pkg::CmdClassify;
    tx_idle_en    = 1'b1;
    rx_stall_en   = 1'b1;
    sent_count    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed corners
    send_request(fcgc_pkg::CmdClassify, 64'd0);
    send_request(fcgc_pkg::CmdClassify, 64'd0);
    send_request(fcgc_pkg::CmdClassify, 64'd10);
    send_request(fcgc_pkg::CmdClassify, 64'd20);
    send_request(fcgc_pkg::CmdClassify, 64'd20);
    send_request(fcgc_pkg::CmdClassify, 64'd5);
    send_request(fcgc_pkg::CmdClassify, 64'd35);
    send_request(fcgc_pkg::CmdClassify, 64'd55);
    send_request(fcgc_pkg::CmdClassify, 64'd105);
    send_request(fcgc_pkg::CmdClassify, 64'd108);
    send_request(fcgc_pkg::CmdClear, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(fcgc_pkg::CmdClassify, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(fcgc_pkg::CmdClassify, 64'hFFFF_FFFF_FFFF_FFFE);
    send_request(fcgc_pkg::CmdClassify, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(fcgc_pkg::CmdClear, 64'd0);
    send_request(fcgc_pkg::CmdClassify, 64'd0);
    send_request(fcgc_pkg::CmdClassify, 64'd1);
    send_request(fcgc_pkg::CmdClassify, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(fcgc_pkg::CmdClear, 64'h5555_5555_5555_5555);
    send_request(fcgc_pkg::CmdClassify, 64'h8000_0000_0000_0000);
    send_request(fcgc_pkg::CmdClassify, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(fcgc_pkg::CmdClassify, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(fcgc_pkg::CmdClear, 64'd0);
    send_request(fcgc_pkg::CmdClear, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(fcgc_pkg::CmdClassify, 64'h5555_5555_5555_5555);

    // Random streams; the last stretch runs without idling
    sent_count = 0;
    while (sent_count < RandomItems) begin
      if (sent_count + 200 >= RandomItems) begin
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
      end else begin
        tx_idle_en  = ($urandom_range(0, 2) != 0);
        rx_stall_en = ($urandom_range(0, 2) != 0);
      end
      run_frame_stream($urandom_range(4, 40));
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    for (int c = 0; c < 5000 && check_pending != 0; c++) @(negedge clk);
    repeat (QuietTail) @(negedge clk);
    if (check_failures == 0 && check_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fcgc_pkg.sv
hw/rtl/frame_counter_gap_classifier.sv
hw/rtl/fcgc_checker.sv
bench/fcgc_checker.sv
bench/testbench.sv
